// File: hdl/hdtc_pkg.sv
package hdtc_pkg;

  // One holiday table entry: day of month, month, day type.
  typedef struct packed {
    logic [4:0] day;
    logic [3:0] month;
    logic [1:0] kind;
  } entry_t;

  localparam logic [1:0] TYPE_WEEKDAY  = 2'd0;
  localparam logic [1:0] TYPE_SATURDAY = 2'd1;
  localparam logic [1:0] TYPE_SUNDAY   = 2'd2;

  localparam logic OP_WRITE    = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  // Register select, taken from paddr[2].
  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_COUNT  = 1'b1;

  // Days before the first of each month, non-leap year. Codes outside 1..12 give 0.
  function automatic logic [8:0] month_start(input logic [3:0] month);
    logic [8:0] r;
    unique case (month)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // x mod 7 by folding octal digits (8 is 1 mod 7).
  function automatic logic [2:0] mod7(input logic [9:0] x);
    logic [4:0] a;
    logic [3:0] b;
    a = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[9]);
    b = 4'(a[2:0]) + 4'(a[4:3]);
    return (b >= 4'd7) ? 3'(b - 4'd7) : b[2:0];
  endfunction

endpackage

// File: hdl/holiday_day_type_classifier.sv
// Holiday day-type classifier.
//
// Item channel: an item is taken at a rising edge with start high and busy
// low. op selects a table write (entry_index/day/month/type) or a date
// classification (date_day/month/year, year counted from 2000).
// A write updates one slot of the holiday table at the accept edge and gives
// no result; busy stays low, so another item may follow in the next cycle.
// A classify item gives exactly one result: day_type and from_holiday_list,
// shown for one cycle with done high. The receiver cannot stall; the result
// must be taken in that cycle. With classification disabled, a classify item
// answers in the cycle after it is taken. Else up to holiday_count entries
// (capped at MAX_HOLIDAYS) are scanned, stopping at the first match, from a
// simple dual-port synchronous RAM read one entry per cycle; with no match a
// weekday step follows. busy is high while the scan or weekday step runs.
// Configuration: APB registers classify_enable at 0x0 and holiday_count at
// 0x4, written only while idle: a duty of the user, as the block does not
// enforce it. Reset clears both registers, the control state and the per-entry
// valid bits, so the table reads as all zero.
module holiday_day_type_classifier import hdtc_pkg::*; #(
  parameter int MAX_HOLIDAYS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [4:0]  entry_index,
  input  logic [4:0]  entry_day,
  input  logic [3:0]  entry_month,
  input  logic [1:0]  entry_type,
  input  logic [4:0]  date_day,
  input  logic [3:0]  date_month,
  input  logic [6:0]  date_year,
  // result channel
  output logic        done,
  output logic [1:0]  day_type,
  output logic        from_holiday_list,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW    = (MAX_HOLIDAYS > 1) ? $clog2(MAX_HOLIDAYS) : 1;
  localparam int CW    = $clog2(MAX_HOLIDAYS + 1);
  localparam logic [8:0] MAX_W = 9'(MAX_HOLIDAYS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_WDAY = 2'd2;

  // configuration registers
  logic       classify_enable;
  logic [5:0] holiday_count;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      classify_enable <= 1'b0;
      holiday_count   <= 6'd0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_ENABLE: classify_enable <= pwdata[0];
        REG_COUNT:  holiday_count   <= pwdata[5:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ENABLE: prdata = {31'd0, classify_enable};
      REG_COUNT:  prdata = {26'd0, holiday_count};
      default:    prdata = 32'd0;
    endcase
  end

  // control and datapath registers
  logic [1:0]    state, state_next;
  logic [CW-1:0] scan_addr, scan_addr_next;
  logic [CW-1:0] limit;
  logic          pend, pend_next;
  logic [4:0]    d_day;
  logic [3:0]    d_month;
  logic [6:0]    d_year;

  logic          accept;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [AW-1:0] mem_ra;
  entry_t        mem_wd;
  entry_t        rd_data;
  logic          rd_valid;
  entry_t        cur;
  logic          hit;
  logic          more;

  logic          done_next;
  logic [1:0]    type_next;
  logic          from_next;

  assign accept = start & ~busy;
  assign busy   = (state != ST_IDLE);

  // table write path; slots beyond the table are dropped, type 3 stored as Sunday
  assign mem_we = accept && (op == OP_WRITE) && ({4'd0, entry_index} < MAX_W);
  assign mem_wa = AW'(entry_index);
  assign mem_wd = '{day: entry_day, month: entry_month,
                    kind: (entry_type > TYPE_SUNDAY) ? TYPE_SUNDAY : entry_type};
  assign mem_ra = scan_addr[AW-1:0];

  // holiday table RAM, one write and one registered read per cycle
  entry_t table_mem [MAX_HOLIDAYS];
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_wa] <= mem_wd;
    end
    rd_data <= table_mem[mem_ra];
  end

  // per-entry valid bits: a never-written slot reads as all zero
  logic [MAX_HOLIDAYS-1:0] valid;
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (mem_we) begin
      valid[mem_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_valid <= valid[mem_ra];
  end

  assign cur  = rd_valid ? rd_data : entry_t'('0);
  assign hit  = pend && (cur.day == d_day) && (cur.month == d_month);
  assign more = (scan_addr < limit);

  // Weekday, leap every 4th year, Monday = 0, mod 7 on the fly (365 is 1 mod 7)
  logic [7:0] year_p3;
  logic [9:0] day_sum;
  logic [2:0] wday;
  logic       leap_add;

  always_comb begin
    year_p3  = 8'(d_year) + 8'd3;
    leap_add = (d_year[1:0] == 2'd0) && (d_month > 4'd2) && (d_month <= 4'd12);
    day_sum  = 10'(d_year) + 10'(year_p3[7:2]) + 10'(month_start(d_month))
             + 10'(leap_add) + 10'(d_day) + 10'd4;
    wday     = mod7(day_sum);
  end

  // sequencer
  always_comb begin
    state_next     = state;
    scan_addr_next = scan_addr;
    pend_next      = 1'b0;
    done_next      = 1'b0;
    type_next      = day_type;
    from_next      = from_holiday_list;
    unique case (state)
      ST_IDLE: begin
        if (accept && (op == OP_CLASSIFY)) begin
          scan_addr_next = '0;
          if (!classify_enable) begin
            done_next = 1'b1;
            type_next = TYPE_WEEKDAY;
            from_next = 1'b0;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          done_next  = 1'b1;
          type_next  = cur.kind;
          from_next  = 1'b1;
          state_next = ST_IDLE;
        end else if (more) begin
          pend_next      = 1'b1;
          scan_addr_next = scan_addr + CW'(1);
        end else begin
          state_next = ST_WDAY;
        end
      end
      ST_WDAY: begin
        done_next  = 1'b1;
        from_next  = 1'b0;
        type_next  = (wday < 3'd5) ? TYPE_WEEKDAY :
                     ((wday == 3'd5) ? TYPE_SATURDAY : TYPE_SUNDAY);
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
      done  <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_addr         <= scan_addr_next;
    day_type          <= type_next;
    from_holiday_list <= from_next;
    if (accept) begin
      d_day   <= date_day;
      d_month <= date_month;
      d_year  <= date_year;
      limit   <= ({3'd0, holiday_count} < MAX_W) ? CW'(holiday_count)
                                                  : CW'(MAX_HOLIDAYS);
    end
  end

endmodule

// File: hdl/hdtc_checker.sv
module hdtc_checker import hdtc_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       op,
  input logic       done,
  input logic [1:0] day_type
);

  // no result straight out of reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  // a write item never produces a result and never stalls the channel
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == OP_WRITE) |=> (!done && !busy))
    else $error("write item produced a result or busy");

  // a classify item either answers at once or starts working
  a_classify_moves: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == OP_CLASSIFY) |=> (done || busy))
    else $error("classify item dropped");

  // day type code 3 is never reported
  a_type_legal: assert property (@(posedge clk) disable iff (rst)
    done |-> (day_type != 2'd3))
    else $error("illegal day type");

endmodule

bind holiday_day_type_classifier hdtc_checker u_hdtc_checker (.*);

// File: dv/testbench.sv
module testbench;
  import hdtc_pkg::*;

  localparam int TABLE_DEPTH  = 32;
  // Worst case: a full scan (capped at the table size), then the weekday step;
  // leave some margin before touching the registers or ending the run.
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 100;

  // One item as seen on the command port. Every field is driven on every
  // item; op decides which group the block looks at.
  typedef struct {
    logic       op;
    logic [4:0] entry_index;
    logic [4:0] entry_day;
    logic [3:0] entry_month;
    logic [1:0] entry_type;
    logic [4:0] date_day;
    logic [3:0] date_month;
    logic [6:0] date_year;
  } day_cmd_t;

  typedef struct {
    logic [1:0] kind;
    logic       listed;
  } day_result_t;

  // Mirrors the holiday table and both registers, predicts the day type of
  // every classify item at accept time and holds the predictions in order.
  class day_type_scoreboard;
    entry_t      holiday_table[TABLE_DEPTH];
    logic        enable;
    logic [5:0]  count;
    int unsigned month_offset[16];
    day_result_t expected_types[$];
    int          errors;

    function new();
      foreach (holiday_table[i]) holiday_table[i] = '0;
      enable = 1'b0;
      count  = '0;
      errors = 0;
      month_offset = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334,
                       0, 0, 0};
    endfunction

    // Weekday from 2000-01-01 (Monday = 0), leap every 4th year, folded to a day type.
    // Out-of-range months count from January with no leap day; day 0 and
    // days past month end just run on arithmetically.
    function logic [1:0] calendar_type(logic [4:0] d, logic [3:0] m, logic [6:0] y);
      int unsigned days;
      int unsigned wd;
      days = y * 365 + (y + 3) / 4 + month_offset[m] + d;
      if (y[1:0] == 2'b00 && m > 4'd2 && m <= 4'd12) days += 1;
      wd = (days + 4) % 7;
      if (wd < 5) return TYPE_WEEKDAY;
      return (wd == 5) ? TYPE_SATURDAY : TYPE_SUNDAY;
    endfunction

    function void note_item(day_cmd_t c);
      day_result_t r;
      int          limit;
      if (c.op == OP_WRITE) begin
        holiday_table[c.entry_index].day   = c.entry_day;
        holiday_table[c.entry_index].month = c.entry_month;
        holiday_table[c.entry_index].kind  =
          (c.entry_type == 2'd3) ? TYPE_SUNDAY : c.entry_type;
        return;
      end
      r.kind   = TYPE_WEEKDAY;
      r.listed = 1'b0;
      if (enable) begin
        limit = (count > TABLE_DEPTH) ? TABLE_DEPTH : int'(count);
        for (int i = 0; i < limit; i++) begin
          if (!r.listed && holiday_table[i].day == c.date_day &&
              holiday_table[i].month == c.date_month) begin
            r.kind   = holiday_table[i].kind;
            r.listed = 1'b1;
          end
        end
        if (!r.listed) r.kind = calendar_type(c.date_day, c.date_month, c.date_year);
      end
      expected_types.push_back(r);
    endfunction

    function void check_result(logic [1:0] kind, logic listed);
      day_result_t e;
      if (expected_types.size() == 0) begin
        $error("result with nothing expected: day_type=%0d from_holiday_list=%0d",
               kind, listed);
        errors++;
        return;
      end
      e = expected_types.pop_front();
      if (kind !== e.kind) begin
        $error("day_type: expected %0d, got %0d", e.kind, kind);
        errors++;
      end
      if (listed !== e.listed) begin
        $error("from_holiday_list: expected %0d, got %0d", e.listed, listed);
        errors++;
      end
    endfunction

    function int pending();
      return expected_types.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        op;
  logic [4:0]  entry_index;
  logic [4:0]  entry_day;
  logic [3:0]  entry_month;
  logic [1:0]  entry_type;
  logic [4:0]  date_day;
  logic [3:0]  date_month;
  logic [6:0]  date_year;
  logic        done;
  logic [1:0]  day_type;
  logic        from_holiday_list;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  day_type_scoreboard sb = new();
  // High while the sender must not pause between items.
  bit quiet = 1'b0;

  holiday_day_type_classifier i_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .op               (op),
    .entry_index      (entry_index),
    .entry_day        (entry_day),
    .entry_month      (entry_month),
    .entry_type       (entry_type),
    .date_day         (date_day),
    .date_month       (date_month),
    .date_year        (date_year),
    .done             (done),
    .day_type         (day_type),
    .from_holiday_list(from_holiday_list),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Watchdog: far beyond the slowest legal run (about 1000 items).
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // Monitor. Values are read at the edge, before any NBA lands, so the
  // accept and the result strobe are judged on what the block saw.
  // One process for both keeps the order of note and check fixed.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        sb.note_item('{op, entry_index, entry_day, entry_month, entry_type,
                       date_day, date_month, date_year});
      end
      if (done) sb.check_result(day_type, from_holiday_list);
    end
  end

  // Random content for every field; callers override what matters.
  function automatic day_cmd_t any_cmd();
    day_cmd_t c;
    c.op          = 1'($urandom_range(0, 1));
    c.entry_index = 5'($urandom_range(0, 31));
    c.entry_day   = 5'($urandom_range(0, 31));
    c.entry_month = 4'($urandom_range(0, 15));
    c.entry_type  = 2'($urandom_range(0, 3));
    c.date_day    = 5'($urandom_range(0, 31));
    c.date_month  = 4'($urandom_range(0, 15));
    c.date_year   = 7'($urandom_range(0, 127));
    return c;
  endfunction

  function automatic day_cmd_t write_cmd(logic [4:0] idx, logic [4:0] d, logic [3:0] m,
                                         logic [1:0] t);
    day_cmd_t c;
    c = any_cmd();
    c.op          = OP_WRITE;
    c.entry_index = idx;
    c.entry_day   = d;
    c.entry_month = m;
    c.entry_type  = t;
    return c;
  endfunction

  function automatic day_cmd_t classify_cmd(logic [4:0] d, logic [3:0] m, logic [6:0] y);
    day_cmd_t c;
    c = any_cmd();
    c.op         = OP_CLASSIFY;
    c.date_day   = d;
    c.date_month = m;
    c.date_year  = y;
    return c;
  endfunction

  // Present one item and hold it until taken. start stays high into the
  // next item unless the sender idles first, so it is never dropped and
  // raised in the same step. Each idle cycle is drawn on its own.
  task automatic send_cmd(day_cmd_t c);
    while (!quiet && $urandom_range(0, 99) < 7) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    op          <= c.op;
    entry_index <= c.entry_index;
    entry_day   <= c.entry_day;
    entry_month <= c.entry_month;
    entry_type  <= c.entry_type;
    date_day    <= c.date_day;
    date_month  <= c.date_month;
    date_year   <= c.date_year;
    do @(posedge clk); while (busy);
  endtask

  // Stop sending and let every outstanding classification come back.
  // Writes give no result, so a last scan may still be running: pad it.
  task automatic quiesce();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup, access, then idle with psel low.
  task automatic write_reg(logic sel, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == REG_ENABLE) sb.enable = value[0];
    else sb.count = value[5:0];
    @(posedge clk);
  endtask

  task automatic set_mode(logic en, logic [5:0] cnt);
    quiesce();
    write_reg(REG_ENABLE, {31'd0, en});
    write_reg(REG_COUNT, {26'd0, cnt});
  endtask

  initial begin
    day_cmd_t   cmd;
    int         pick;
    int         slot;
    logic       en;
    logic [5:0] cnt;

    rst         <= 1'b1;
    start       <= 1'b0;
    op          <= OP_WRITE;
    entry_index <= '0;
    entry_day   <= '0;
    entry_month <= '0;
    entry_type  <= '0;
    date_day    <= '0;
    date_month  <= '0;
    date_year   <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed ---
    // Reset state: classification off, everything reads as weekday.
    send_cmd(classify_cmd(5'd1, 4'd1, 7'd0));
    set_mode(1'b1, 6'd32);
    send_cmd(write_cmd(5'd0, 5'd25, 4'd12, TYPE_SATURDAY));
    // same date again later in the table: the first entry must win
    send_cmd(write_cmd(5'd1, 5'd25, 4'd12, TYPE_SUNDAY));
    // type code 3 folds to Sunday; top slot, out-of-range month
    send_cmd(write_cmd(5'd31, 5'd31, 4'd15, 2'd3));
    send_cmd(write_cmd(5'd5, 5'd1, 4'd1, TYPE_WEEKDAY));
    send_cmd(classify_cmd(5'd25, 4'd12, 7'd5));
    // untouched slots still hold day 0 / month 0 and match such a date
    send_cmd(classify_cmd(5'd0, 4'd0, 7'd0));
    send_cmd(classify_cmd(5'd31, 4'd15, 7'd127));
    send_cmd(classify_cmd(5'd1, 4'd1, 7'd0));
    // calendar path: Jan 2 2000 Sunday, Jan 3 Monday, leap day, March
    send_cmd(classify_cmd(5'd2, 4'd1, 7'd0));
    send_cmd(classify_cmd(5'd3, 4'd1, 7'd0));
    send_cmd(classify_cmd(5'd29, 4'd2, 7'd0));
    send_cmd(classify_cmd(5'd1, 4'd3, 7'd0));
    // bad month, day 0, last year the fields allow
    send_cmd(classify_cmd(5'd31, 4'd13, 7'd99));
    send_cmd(classify_cmd(5'd0, 4'd1, 7'd0));
    send_cmd(classify_cmd(5'd31, 4'd12, 7'd127));
    // empty table in use: calendar only, even for day 0 / month 0
    set_mode(1'b1, 6'd0);
    send_cmd(classify_cmd(5'd25, 4'd12, 7'd5));
    send_cmd(classify_cmd(5'd0, 4'd0, 7'd0));
    // count past the table size: the search stops at the last slot
    set_mode(1'b1, 6'd63);
    send_cmd(classify_cmd(5'd31, 4'd15, 7'd127));
    set_mode(1'b0, 6'd63);
    send_cmd(classify_cmd(5'd25, 4'd12, 7'd5));

    // --- random phases, each with its own register setting ---
    for (int phase = 0; phase < PHASES; phase++) begin
      en = (phase == 4) ? 1'b0 : ($urandom_range(0, 7) != 0);
      case (phase)
        0: cnt = 6'd32;
        1: cnt = 6'd63;
        2: cnt = 6'd1;
        default: begin
          case ($urandom_range(0, 3))
            0: cnt = 6'd0;
            1: cnt = 6'($urandom_range(1, 31));
            2: cnt = 6'd32;
            default: cnt = 6'($urandom_range(33, 63));
          endcase
        end
      endcase
      set_mode(en, cnt);
      // one phase runs back to back with no sender gaps
      quiet = (phase == 5);
      repeat (PHASE_ITEMS) begin
        // now and then hold off until the block has drained completely
        if (!quiet && $urandom_range(0, 99) == 0) quiesce();
        cmd  = any_cmd();
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          cmd.op = OP_WRITE;
          // mostly real calendar dates, some junk
          if ($urandom_range(0, 4) != 0) begin
            cmd.entry_day   = 5'($urandom_range(1, 31));
            cmd.entry_month = 4'($urandom_range(1, 12));
          end
        end else begin
          cmd.op = OP_CLASSIFY;
          pick = $urandom_range(0, 99);
          if (pick < 40) begin
            // aim at a stored entry so the table decides often
            slot = $urandom_range(0, TABLE_DEPTH - 1);
            cmd.date_day   = sb.holiday_table[slot].day;
            cmd.date_month = sb.holiday_table[slot].month;
            cmd.date_year  = 7'($urandom_range(0, 99));
          end else if (pick < 85) begin
            cmd.date_day   = 5'($urandom_range(1, 31));
            cmd.date_month = 4'($urandom_range(1, 12));
            cmd.date_year  = 7'($urandom_range(0, 99));
          end
        end
        send_cmd(cmd);
      end
      quiet = 1'b0;
    end

    quiesce();
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
